/* design/arfp_pkg.sv */
// Package: constants, codes and types of the receive frame parser.
`default_nettype none
package arfp_pkg;

  localparam int MAX_DATA_BYTES = 64;
  localparam int MIN_FRAME_LEN  = 13;
  localparam int HEADER_LEN     = 14;
  localparam int PCNT_W         = $clog2(MAX_DATA_BYTES + 1);
  localparam int BCNT_W         = $clog2(HEADER_LEN + MAX_DATA_BYTES + 2);

  localparam logic [7:0]  DELIM          = 8'h7E;
  localparam logic [7:0]  TYPE_RESET     = 8'h90;
  localparam logic [7:0]  CHECK_BASE     = 8'hFF;
  localparam logic [15:0] LEN_MSB_MASK   = 16'hFF00;
  localparam logic [3:0]  ADDR_LAST      = 4'd8;
  localparam logic [0:0]  REG_FRAME_TYPE = 1'b0;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_START   = 2'd1;
  localparam logic [1:0] ST_VALID   = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  typedef enum logic [11:0] {
    PH_WAIT    = 12'b0000_0000_0001,
    PH_LEN_MSB = 12'b0000_0000_0010,
    PH_LEN_LSB = 12'b0000_0000_0100,
    PH_TYPE    = 12'b0000_0000_1000,
    PH_ADDR    = 12'b0000_0001_0000,
    PH_NET_MSB = 12'b0000_0010_0000,
    PH_NET_LSB = 12'b0000_0100_0000,
    PH_OPTIONS = 12'b0000_1000_0000,
    PH_OP      = 12'b0001_0000_0000,
    PH_SENDER  = 12'b0010_0000_0000,
    PH_DATA    = 12'b0100_0000_0000,
    PH_CHECK   = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic [7:0]          sum;
    logic [15:0]         declared_length;
    logic [BCNT_W-1:0]   bytes_counted;
    logic [3:0]          address_count;
    logic [PCNT_W-1:0]   payload_count;
    logic [7:0]          op_latch;
    logic [7:0]          sender_latch;
  } parse_state_t;

  typedef struct packed {
    logic [6:0] packet_data_len;
    logic [7:0] packet_sender;
    logic [7:0] packet_op;
    logic [5:0] data_index;
    logic [7:0] data_byte;
    logic       data_valid;
    logic [1:0] parse_status;
  } result_t;

endpackage
`default_nettype wire

/* design/arfp_step.sv */
// Next-state and result logic of the parser for one received byte.
`default_nettype none
module arfp_step (
  input  arfp_pkg::parse_state_t state,
  input  logic [7:0]             rx_byte,
  input  logic [7:0]             accepted_frame_type,
  output arfp_pkg::parse_state_t state_next,
  output arfp_pkg::result_t      result
);
  import arfp_pkg::*;

  logic [BCNT_W-1:0] bc_inc;
  logic [7:0]        sum_inc;
  logic              len_hit;
  logic [15:0]       len_full;
  logic [7:0]        check_val;

  assign bc_inc    = state.bytes_counted + BCNT_W'(1);
  assign sum_inc   = state.sum + rx_byte;
  assign len_hit   = (16'(bc_inc) == state.declared_length);
  assign len_full  = state.declared_length | {8'h00, rx_byte};
  assign check_val = CHECK_BASE - state.sum;

  always_comb begin
    state_next          = state;
    result.parse_status = ST_IDLE;
    result.data_valid   = 1'b0;
    result.data_byte    = 8'h00;
    result.data_index   = 6'd0;
    if (state.phase != PH_CHECK && rx_byte == DELIM) begin
      state_next          = '0;
      state_next.phase    = PH_LEN_MSB;
      result.parse_status = ST_START;
    end else begin
      case (state.phase)
        PH_LEN_MSB: begin
          state_next.declared_length = {rx_byte, 8'h00} & LEN_MSB_MASK;
          state_next.phase           = PH_LEN_LSB;
        end
        PH_LEN_LSB: begin
          state_next.declared_length = len_full;
          state_next.bytes_counted   = '0;
          if (len_full < 16'(MIN_FRAME_LEN) ||
              len_full > 16'(HEADER_LEN + MAX_DATA_BYTES)) begin
            result.parse_status = ST_INVALID;
            state_next.phase    = PH_WAIT;
          end else begin
            state_next.phase = PH_TYPE;
          end
        end
        PH_TYPE: begin
          state_next.bytes_counted = bc_inc;
          state_next.sum           = sum_inc;
          if (rx_byte == accepted_frame_type) begin
            state_next.phase = PH_ADDR;
          end else begin
            result.parse_status = ST_INVALID;
            state_next.phase    = PH_WAIT;
          end
        end
        PH_ADDR: begin
          state_next.bytes_counted = bc_inc;
          state_next.sum           = sum_inc;
          state_next.address_count = state.address_count + 4'd1;
          if (state_next.address_count >= ADDR_LAST) begin
            state_next.phase = PH_NET_MSB;
          end
        end
        PH_NET_MSB: begin
          state_next.bytes_counted = bc_inc;
          state_next.sum           = sum_inc;
          state_next.phase         = PH_NET_LSB;
        end
        PH_NET_LSB: begin
          state_next.bytes_counted = bc_inc;
          state_next.sum           = sum_inc;
          state_next.phase         = PH_OPTIONS;
        end
        PH_OPTIONS: begin
          state_next.bytes_counted = bc_inc;
          state_next.sum           = sum_inc;
          state_next.phase         = PH_OP;
        end
        PH_OP: begin
          state_next.bytes_counted = bc_inc;
          state_next.sum           = sum_inc;
          state_next.op_latch      = rx_byte;
          state_next.phase         = len_hit ? PH_CHECK : PH_SENDER;
        end
        PH_SENDER: begin
          state_next.bytes_counted = bc_inc;
          state_next.sum           = sum_inc;
          state_next.sender_latch  = rx_byte;
          state_next.phase         = len_hit ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          if (state.payload_count >= PCNT_W'(MAX_DATA_BYTES)) begin
            result.parse_status = ST_INVALID;
            state_next.phase    = PH_WAIT;
          end else begin
            state_next.bytes_counted = bc_inc;
            state_next.sum           = sum_inc;
            result.data_valid        = 1'b1;
            result.data_byte         = rx_byte;
            result.data_index        = state.payload_count[5:0];
            state_next.payload_count = state.payload_count + PCNT_W'(1);
            state_next.phase         = len_hit ? PH_CHECK : PH_DATA;
          end
        end
        PH_CHECK: begin
          result.parse_status = (check_val == rx_byte) ? ST_VALID : ST_INVALID;
          state_next.phase    = PH_WAIT;
        end
        default: begin
          state_next.phase = PH_WAIT;
        end
      endcase
    end
    result.packet_op       = state_next.op_latch;
    result.packet_sender   = state_next.sender_latch;
    result.packet_data_len = 7'(state_next.payload_count);
  end

endmodule
`default_nettype wire

/* design/api_receive_frame_parser_unit.sv */
// Top level: receive frame parser with stream ports, skid buffer and register port.
// Each accepted byte's result is registered into the output stage, or into the skid stage while the output is held.
// Throughput: one byte per cycle while the skid stage is empty; parser state updates in a single pass per byte.
// A two-entry output (register plus skid) lets a byte be taken while a result waits.
// Reset (rst, synchronous, active high) clears the parser state, empties the
// output stages and sets accepted_frame_type to 0x90.
`default_nettype none
module api_receive_frame_parser_unit (
  input  logic        clk,
  input  logic        rst,
  // tdata: rx_byte[7:0]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  // tdata: parse_status[1:0], data_valid[2], data_byte[10:3], data_index[16:11],
  //        packet_op[24:17], packet_sender[32:25], packet_data_len[39:33]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import arfp_pkg::*;

  parse_state_t state;
  parse_state_t state_next;
  result_t      result;
  logic [7:0]   accepted_frame_type;
  logic         out_valid;
  logic [39:0]  out_data;
  logic         skid_valid;
  logic [39:0]  skid_data;
  logic         in_accept;
  logic         out_free;

  arfp_step u_step (
    .state               (state),
    .rx_byte             (s_tdata),
    .accepted_frame_type (accepted_frame_type),
    .state_next          (state_next),
    .result              (result)
  );

  assign s_tready  = !skid_valid;
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = m_tready || !out_valid;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FRAME_TYPE) ? {24'h0, accepted_frame_type} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_frame_type <= TYPE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_FRAME_TYPE) begin
      accepted_frame_type <= pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_WAIT, default: '0};
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
        out_data  <= result;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
      skid_data  <= result;
    end
  end

`ifndef ASSERT_OFF
  a_data_only_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2]) |-> (m_tdata[1:0] == ST_IDLE))
    else $error("data byte reported with nonzero status");

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full while output stage empty");

  a_payload_bound: assert property (@(posedge clk) disable iff (rst)
    state.payload_count <= PCNT_W'(MAX_DATA_BYTES))
    else $error("payload count beyond maximum");

  a_reset_wait: assert property (@(posedge clk)
    $past(rst) |-> (state.phase == PH_WAIT && !out_valid && !skid_valid))
    else $error("parser not idle after reset");
`endif

endmodule
`default_nettype wire

/* tb/sv/api_receive_frame_parser_unit_tb.sv */
// Testbench of the receive frame parser: directed and random byte streams against a predictor.
`timescale 1ns / 100ps
module api_receive_frame_parser_unit_tb;
  import arfp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int RANDOM_BYTES   = 1200;
  localparam int FRAME_LEN_MAX  = HEADER_LEN + MAX_DATA_BYTES;
  localparam logic [2:0] FRAME_TYPE_ADDR = 3'(REG_FRAME_TYPE) << 2;

  localparam logic [1:0] READY_ALWAYS = 2'd0;
  localparam logic [1:0] READY_RANDOM = 2'd1;
  localparam logic [1:0] READY_3OF4   = 2'd2;
  localparam logic [1:0] READY_SPARSE = 2'd3;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // tdata: rx_byte[7:0]
  logic [7:0]  s_tdata  = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // tdata: parse_status[1:0], data_valid[2], data_byte[10:3], data_index[16:11],
  //        packet_op[24:17], packet_sender[32:25], packet_data_len[39:33]
  logic [39:0] m_tdata;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = 3'd0;
  logic [31:0] pwdata   = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  api_receive_frame_parser_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // parser copy
  logic [7:0]  frame_type_cfg = TYPE_RESET;
  phase_t      rx_phase       = PH_WAIT;
  logic [7:0]  rx_sum         = 8'h00;
  logic [15:0] rx_len         = 16'h0000;
  logic [15:0] rx_count       = 16'h0000;
  logic [3:0]  rx_addr        = 4'h0;
  logic [6:0]  rx_payload     = 7'h00;
  logic [7:0]  rx_op          = 8'h00;
  logic [7:0]  rx_sender      = 8'h00;

  result_t predicted_results[$];
  result_t want_r, got_r;
  int      bytes_sent  = 0;
  int      burst_left  = 0;
  bit      gaps_on     = 1'b1;
  int      mismatches  = 0;
  int      idle_cycles = 0;
  logic [9:0] stall_cycle = 10'd0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void note_mismatch(input string what, input logic [39:0] want,
                                        input logic [39:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
  endfunction

  function automatic void tally(input logic [7:0] c);
    rx_count = rx_count + 16'd1;
    rx_sum   = rx_sum + c;
  endfunction

  function automatic result_t parse_rx_byte(input logic [7:0] c);
    result_t r;
    r = '0;
    if (rx_phase != PH_CHECK && c == DELIM) begin
      rx_phase   = PH_LEN_MSB;
      rx_sum     = 8'h00;
      rx_len     = 16'h0000;
      rx_count   = 16'h0000;
      rx_addr    = 4'h0;
      rx_payload = 7'h00;
      rx_op      = 8'h00;
      rx_sender  = 8'h00;
      r.parse_status = ST_START;
    end else begin
      case (rx_phase)
        PH_LEN_MSB: begin
          rx_len   = {c, 8'h00} & LEN_MSB_MASK;
          rx_phase = PH_LEN_LSB;
        end
        PH_LEN_LSB: begin
          rx_len   = rx_len | {8'h00, c};
          rx_count = 16'h0000;
          if (rx_len < MIN_FRAME_LEN || rx_len > FRAME_LEN_MAX) begin
            r.parse_status = ST_INVALID;
            rx_phase = PH_WAIT;
          end else begin
            rx_phase = PH_TYPE;
          end
        end
        PH_TYPE: begin
          tally(c);
          if (c == frame_type_cfg) begin
            rx_phase = PH_ADDR;
          end else begin
            r.parse_status = ST_INVALID;
            rx_phase = PH_WAIT;
          end
        end
        PH_ADDR: begin
          tally(c);
          rx_addr = rx_addr + 4'd1;
          if (rx_addr >= ADDR_LAST) rx_phase = PH_NET_MSB;
        end
        PH_NET_MSB: begin
          tally(c);
          rx_phase = PH_NET_LSB;
        end
        PH_NET_LSB: begin
          tally(c);
          rx_phase = PH_OPTIONS;
        end
        PH_OPTIONS: begin
          tally(c);
          rx_phase = PH_OP;
        end
        PH_OP: begin
          tally(c);
          rx_op    = c;
          rx_phase = (rx_count == rx_len) ? PH_CHECK : PH_SENDER;
        end
        PH_SENDER: begin
          tally(c);
          rx_sender = c;
          rx_phase  = (rx_count == rx_len) ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          if (rx_payload >= MAX_DATA_BYTES) begin
            r.parse_status = ST_INVALID;
            rx_phase = PH_WAIT;
          end else begin
            tally(c);
            r.data_valid = 1'b1;
            r.data_byte  = c;
            r.data_index = rx_payload[5:0];
            rx_payload   = rx_payload + 7'd1;
            rx_phase     = (rx_count == rx_len) ? PH_CHECK : PH_DATA;
          end
        end
        PH_CHECK: begin
          r.parse_status = (CHECK_BASE - rx_sum == c) ? ST_VALID : ST_INVALID;
          rx_phase = PH_WAIT;
        end
        default: rx_phase = PH_WAIT;
      endcase
    end
    r.packet_op       = rx_op;
    r.packet_sender   = rx_sender;
    r.packet_data_len = rx_payload;
    return r;
  endfunction

  function automatic logic [7:0] clean_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == DELIM);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    predicted_results.push_back(parse_rx_byte(b));
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [15:0] len, input logic [7:0] ftype,
                            input bit bad_sum, input int cut);
    logic [7:0] frame[$];
    logic [7:0] sum, b;
    int i, n;
    frame.push_back(DELIM);
    frame.push_back(len[15:8]);
    frame.push_back(len[7:0]);
    if (len >= MIN_FRAME_LEN && len <= FRAME_LEN_MAX) begin
      frame.push_back(ftype);
      sum = ftype;
      for (i = 1; i < len; i++) begin
        b = clean_byte();
        frame.push_back(b);
        sum = sum + b;
      end
      b = CHECK_BASE - sum;
      if (bad_sum) b = b ^ 8'($urandom_range(1, 255));
      frame.push_back(b);
    end else begin
      repeat ($urandom_range(0, 3)) frame.push_back(clean_byte());
    end
    n = (cut > 0 && cut < frame.size()) ? cut : frame.size();
    for (i = 0; i < n; i++) send_byte(frame[i]);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_frame_type(input logic [7:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FRAME_TYPE_ADDR;
    pwdata  <= 32'(value);
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    frame_type_cfg = value;
    @(negedge clk) begin
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== value)
      note_mismatch("accepted_frame_type readback", 40'(value), 40'(prdata[7:0]));
    @(negedge clk) begin
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  task automatic test_directed();
    gaps_on = 1'b1;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_frame(16'(MIN_FRAME_LEN), TYPE_RESET, 1'b0, 0);
    send_frame(16'(HEADER_LEN), TYPE_RESET, 1'b0, 0);
    send_frame(16'(HEADER_LEN + 1), TYPE_RESET, 1'b0, 0);
    send_frame(16'(FRAME_LEN_MAX), TYPE_RESET, 1'b0, 0);
    send_frame(16'd16, TYPE_RESET, 1'b1, 0);
    send_frame(16'd16, TYPE_RESET ^ 8'h01, 1'b0, 0);
    send_frame(16'(MIN_FRAME_LEN - 1), TYPE_RESET, 1'b0, 0);
    send_frame(16'h0000, TYPE_RESET, 1'b0, 0);
    send_frame(16'hFFFF, TYPE_RESET, 1'b0, 0);
    send_frame(16'(FRAME_LEN_MAX + 1), TYPE_RESET, 1'b0, 0);
    send_frame(16'h0100 | 16'(MIN_FRAME_LEN), TYPE_RESET, 1'b0, 0);
    // restart inside the address field
    send_frame(16'd20, TYPE_RESET, 1'b0, 9);
    send_frame(16'd20, TYPE_RESET, 1'b0, 0);
    send_byte(DELIM);
    send_frame(16'd17, TYPE_RESET, 1'b0, 0);
    // checksum byte equal to the delimiter
    send_byte(DELIM);
    send_byte(8'h00);
    send_byte(8'(MIN_FRAME_LEN));
    send_byte(TYPE_RESET);
    repeat (11) send_byte(8'h00);
    send_byte(8'(CHECK_BASE - DELIM - TYPE_RESET));
    send_byte(DELIM);
    wait_idle();
  endtask

  task automatic test_type_extremes();
    gaps_on = 1'b0;
    set_frame_type(8'h00);
    send_frame(16'd15, 8'h00, 1'b0, 0);
    send_frame(16'd15, TYPE_RESET, 1'b0, 0);
    set_frame_type(8'hFF);
    send_frame(16'd15, 8'hFF, 1'b0, 0);
    send_frame(16'(HEADER_LEN), 8'hFE, 1'b0, 0);
    wait_idle();
  endtask

  task automatic test_random();
    int phase_no, kind, target;
    logic [7:0]  ftype;
    logic [15:0] len;
    for (phase_no = 0; phase_no < 4; phase_no++) begin
      ftype = (phase_no == 3) ? TYPE_RESET : 8'($urandom_range(0, 255));
      set_frame_type(ftype);
      gaps_on = (phase_no % 2 == 0);
      target  = bytes_sent + RANDOM_BYTES / 4;
      while (bytes_sent < target) begin
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
          len = 16'($urandom_range(MIN_FRAME_LEN, FRAME_LEN_MAX));
        else
          len = 16'($urandom_range(MIN_FRAME_LEN, MIN_FRAME_LEN + 16));
        if (kind < 70) begin
          send_frame(len, ftype, 1'b0, 0);
        end else if (kind < 78) begin
          send_frame(len, ftype, 1'b1, 0);
        end else if (kind < 84) begin
          send_frame(len, ftype ^ 8'($urandom_range(1, 255)), 1'b0, 0);
        end else if (kind < 90) begin
          case ($urandom_range(0, 2))
            0:       len = 16'($urandom_range(0, MIN_FRAME_LEN - 1));
            1:       len = 16'($urandom_range(FRAME_LEN_MAX + 1, 255));
            default: len = 16'($urandom_range(0, 65535));
          endcase
          send_frame(len, ftype, 1'b0, 0);
        end else if (kind < 95) begin
          send_frame(len, ftype, 1'b0, $urandom_range(1, len + 3));
        end else begin
          repeat ($urandom_range(1, 10))
            send_byte(($urandom_range(0, 7) == 0) ? DELIM : 8'($urandom_range(0, 255)));
        end
      end
    end
    wait_idle();
  endtask

  always @(negedge clk) begin
    stall_cycle <= stall_cycle + 10'd1;
    case (stall_cycle[9:8])
      READY_ALWAYS: m_tready <= 1'b1;
      READY_RANDOM: m_tready <= 1'($urandom_range(0, 1));
      READY_3OF4:   m_tready <= (stall_cycle[1:0] != 2'd0);
      default:      m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_results.size() == 0) begin
        note_mismatch("unexpected result", 40'h0, m_tdata);
      end else begin
        want_r = predicted_results.pop_front();
        got_r  = result_t'(m_tdata);
        if (got_r.parse_status !== want_r.parse_status)
          note_mismatch("parse_status", 40'(want_r.parse_status),
                        40'(got_r.parse_status));
        if (got_r.data_valid !== want_r.data_valid)
          note_mismatch("data_valid", 40'(want_r.data_valid), 40'(got_r.data_valid));
        if (got_r.data_byte !== want_r.data_byte)
          note_mismatch("data_byte", 40'(want_r.data_byte), 40'(got_r.data_byte));
        if (got_r.data_index !== want_r.data_index)
          note_mismatch("data_index", 40'(want_r.data_index), 40'(got_r.data_index));
        if (got_r.packet_op !== want_r.packet_op)
          note_mismatch("packet_op", 40'(want_r.packet_op), 40'(got_r.packet_op));
        if (got_r.packet_sender !== want_r.packet_sender)
          note_mismatch("packet_sender", 40'(want_r.packet_sender),
                        40'(got_r.packet_sender));
        if (got_r.packet_data_len !== want_r.packet_data_len)
          note_mismatch("packet_data_len", 40'(want_r.packet_data_len),
                        40'(got_r.packet_data_len));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("api_receive_frame_parser_unit_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_type_extremes();
    test_random();
    if (mismatches == 0 && predicted_results.size() == 0)
      $display("api_receive_frame_parser_unit_tb: clean");
    else
      $display("api_receive_frame_parser_unit_tb: errors");
    $finish;
  end

endmodule
